// ----- hw/rtl/single_wire_sensor_frame_receiver_unit_macros.svh -----
// Assertion macros shared by the receiver RTL.
// Each macro expects signals named clk and rst_n in the scope of use.
`ifndef SINGLE_WIRE_SENSOR_FRAME_RECEIVER_UNIT_MACROS_SVH
`define SINGLE_WIRE_SENSOR_FRAME_RECEIVER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SWSR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("receiver same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SWSR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("receiver next-cycle check failed");

`endif

// ----- hw/rtl/swsr_pkg.sv -----
package swsr_pkg;

    localparam int TICK_W      = 16;
    localparam int LIMIT_W     = 8;
    localparam int FRAME_W     = 40;
    localparam int HUM_W       = 15;
    localparam int TEMP_W      = 16;
    localparam int PULSE_COUNT = 41;
    localparam int PULSE_W     = $clog2(PULSE_COUNT + 1);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [TICK_W-1:0]  START_LOW_TICKS_RST = 16'd1100;
    localparam logic [LIMIT_W-1:0] ACK_START_LIMIT_RST = 8'd25;
    localparam logic [LIMIT_W-1:0] ACK_END_LIMIT_RST   = 8'd50;
    localparam logic [LIMIT_W-1:0] SYNC_LIMIT_RST      = 8'd70;
    localparam logic [LIMIT_W-1:0] HIGH_LIMIT_RST      = 8'd100;
    localparam logic [LIMIT_W-1:0] BIT_THRESHOLD_RST   = 8'd6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_LOW_TICKS = 3'd0,
        CFG_ACK_START_LIMIT = 3'd1,
        CFG_ACK_END_LIMIT   = 3'd2,
        CFG_SYNC_LIMIT      = 3'd3,
        CFG_HIGH_LIMIT      = 3'd4,
        CFG_BIT_THRESHOLD   = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_START_LOW = 3'd1,
        PH_ACK_START = 3'd2,
        PH_ACK_END   = 3'd3,
        PH_SYNC      = 3'd4,
        PH_HIGH      = 3'd5
    } phase_t;

    typedef struct packed {
        logic [TICK_W-1:0]  start_low_ticks;
        logic [LIMIT_W-1:0] ack_start_limit;
        logic [LIMIT_W-1:0] ack_end_limit;
        logic [LIMIT_W-1:0] sync_limit;
        logic [LIMIT_W-1:0] high_limit;
        logic [LIMIT_W-1:0] bit_threshold;
    } cfg_t;

    typedef struct packed {
        logic                     drive_low;
        logic                     busy;
        logic                     done;
        logic                     error;
        logic [HUM_W-1:0]         humidity;
        logic signed [TEMP_W-1:0] temperature;
    } result_t;

endpackage

// ----- hw/rtl/swsr_cfg.sv -----
module swsr_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [swsr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [swsr_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    output swsr_pkg::cfg_t                      cfg
);
    import swsr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_START_LOW_TICKS: cfg_next.start_low_ticks = cfg_wr_data[TICK_W-1:0];
                CFG_ACK_START_LIMIT: cfg_next.ack_start_limit = cfg_wr_data[LIMIT_W-1:0];
                CFG_ACK_END_LIMIT:   cfg_next.ack_end_limit   = cfg_wr_data[LIMIT_W-1:0];
                CFG_SYNC_LIMIT:      cfg_next.sync_limit      = cfg_wr_data[LIMIT_W-1:0];
                CFG_HIGH_LIMIT:      cfg_next.high_limit      = cfg_wr_data[LIMIT_W-1:0];
                CFG_BIT_THRESHOLD:   cfg_next.bit_threshold   = cfg_wr_data[LIMIT_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_low_ticks <= START_LOW_TICKS_RST;
            cfg_reg.ack_start_limit <= ACK_START_LIMIT_RST;
            cfg_reg.ack_end_limit   <= ACK_END_LIMIT_RST;
            cfg_reg.sync_limit      <= SYNC_LIMIT_RST;
            cfg_reg.high_limit      <= HIGH_LIMIT_RST;
            cfg_reg.bit_threshold   <= BIT_THRESHOLD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hw/rtl/swsr_core.sv -----
module swsr_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic                 req_type,
    input  logic                 line_level,
    input  swsr_pkg::cfg_t       cfg,
    output swsr_pkg::result_t    result
);
    import swsr_pkg::*;

    phase_t                   phase_reg, phase_next;
    logic [TICK_W-1:0]        tick_count_reg, tick_count_next;
    logic [PULSE_W-1:0]       pulse_index_reg, pulse_index_next;
    logic [FRAME_W-1:0]       frame_bits_reg, frame_bits_next;
    logic                     error_seen_reg, error_seen_next;
    logic [HUM_W-1:0]         last_humidity_reg, last_humidity_next;
    logic [TEMP_W-1:0]        last_temperature_reg, last_temperature_next;

    logic [TICK_W-1:0]        tick_inc;
    logic [LIMIT_W-1:0]       wait_limit;
    logic                     want_level;
    logic                     seen;
    logic                     timeout;
    logic                     wait_end;
    logic                     start_end;
    logic                     bit_val;
    logic [FRAME_W-1:0]       frame_shift;
    logic [PULSE_W-1:0]       pulse_inc;
    logic                     last_pulse;
    logic [15:0]              frame_hum;
    logic [15:0]              frame_tmp;
    logic [7:0]               frame_sum;
    logic                     final_error;
    logic [TEMP_W-1:0]        tmp_twos;
    logic                     frame_done;

    // Shared wait and frame arithmetic.
    always_comb
    begin
        tick_inc   = tick_count_reg + TICK_W'(1);
        wait_limit = cfg.high_limit;
        want_level = 1'b0;
        case (phase_reg)
            PH_ACK_START: begin wait_limit = cfg.ack_start_limit; want_level = 1'b1; end
            PH_ACK_END:   begin wait_limit = cfg.ack_end_limit;   want_level = 1'b0; end
            PH_SYNC:      begin wait_limit = cfg.sync_limit;      want_level = 1'b1; end
            default:      begin wait_limit = cfg.high_limit;      want_level = 1'b0; end
        endcase
        seen      = (line_level == want_level);
        timeout   = !seen && (tick_inc > TICK_W'(wait_limit));
        wait_end  = seen || timeout;
        start_end = (tick_inc >= cfg.start_low_ticks);

        bit_val     = (tick_inc > TICK_W'(cfg.bit_threshold));
        frame_shift = {frame_bits_reg[FRAME_W-2:0], bit_val};
        pulse_inc   = pulse_index_reg + PULSE_W'(1);
        last_pulse  = (pulse_inc >= PULSE_W'(PULSE_COUNT));

        frame_hum   = frame_shift[39:24];
        frame_tmp   = frame_shift[23:8];
        frame_sum   = frame_hum[15:8] + frame_hum[7:0] + frame_tmp[15:8] + frame_tmp[7:0];
        final_error = error_seen_reg || timeout || (frame_sum != frame_shift[7:0]);
        if (frame_tmp[15])
            tmp_twos = TEMP_W'(-{1'b0, frame_tmp[14:0]});
        else
            tmp_twos = {1'b0, frame_tmp[14:0]};
    end

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (req_type)
        begin
            if (phase_reg == PH_IDLE)
                phase_next = PH_START_LOW;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:      phase_next = PH_IDLE;
                PH_START_LOW: if (start_end) phase_next = PH_ACK_START;
                PH_ACK_START: if (wait_end)  phase_next = PH_ACK_END;
                PH_ACK_END:   if (wait_end)  phase_next = PH_SYNC;
                PH_SYNC:      if (wait_end)  phase_next = PH_HIGH;
                PH_HIGH:      if (wait_end)  phase_next = last_pulse ? PH_IDLE : PH_SYNC;
                default:      phase_next = PH_IDLE;
            endcase
        end
    end

    // Counters, frame and stored values.
    always_comb
    begin
        tick_count_next       = tick_count_reg;
        pulse_index_next      = pulse_index_reg;
        frame_bits_next       = frame_bits_reg;
        error_seen_next       = error_seen_reg;
        last_humidity_next    = last_humidity_reg;
        last_temperature_next = last_temperature_reg;
        frame_done            = 1'b0;
        if (req_type)
        begin
            if (phase_reg == PH_IDLE)
            begin
                tick_count_next  = '0;
                pulse_index_next = '0;
                frame_bits_next  = '0;
                error_seen_next  = 1'b0;
            end
        end
        else
        begin
            case (phase_reg)
                PH_START_LOW:
                begin
                    tick_count_next = start_end ? '0 : tick_inc;
                end
                PH_ACK_START, PH_ACK_END, PH_SYNC:
                begin
                    tick_count_next = wait_end ? '0 : tick_inc;
                    if (timeout)
                        error_seen_next = 1'b1;
                end
                PH_HIGH:
                begin
                    tick_count_next = wait_end ? '0 : tick_inc;
                    if (timeout)
                        error_seen_next = 1'b1;
                    if (wait_end)
                    begin
                        frame_bits_next  = frame_shift;
                        pulse_index_next = pulse_inc;
                        if (last_pulse)
                        begin
                            pulse_index_next = '0;
                            error_seen_next  = final_error;
                            frame_done       = 1'b1;
                            if (final_error)
                            begin
                                last_humidity_next    = '0;
                                last_temperature_next = '0;
                            end
                            else
                            begin
                                last_humidity_next    = frame_hum[HUM_W-1:0];
                                last_temperature_next = tmp_twos;
                            end
                        end
                    end
                end
                default:
                begin
                    tick_count_next = tick_count_reg;
                end
            endcase
        end
    end

    // Result of the current transaction, taken after the update.
    always_comb
    begin
        result.drive_low   = req_type ? (phase_reg == PH_IDLE) : (phase_reg == PH_START_LOW);
        result.busy        = (phase_next != PH_IDLE);
        result.done        = frame_done;
        result.error       = error_seen_next;
        result.humidity    = last_humidity_next;
        result.temperature = last_temperature_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= PH_IDLE;
            tick_count_reg       <= '0;
            pulse_index_reg      <= '0;
            frame_bits_reg       <= '0;
            error_seen_reg       <= 1'b0;
            last_humidity_reg    <= '0;
            last_temperature_reg <= '0;
        end
        else if (step)
        begin
            phase_reg            <= phase_next;
            tick_count_reg       <= tick_count_next;
            pulse_index_reg      <= pulse_index_next;
            frame_bits_reg       <= frame_bits_next;
            error_seen_reg       <= error_seen_next;
            last_humidity_reg    <= last_humidity_next;
            last_temperature_reg <= last_temperature_next;
        end
    end

endmodule

// ----- hw/rtl/single_wire_sensor_frame_receiver_unit.sv -----
// Single-wire humidity/temperature sensor frame receiver. Each input
// transaction is either one line sample (req_type 0) or a start request
// (req_type 1), and each gives exactly one result transaction carrying the
// line drive, busy, done, error and the most recent humidity and temperature.
// A start request while idle drives the line low for start_low_ticks ticks,
// then the receiver waits for the acknowledge pulse and decodes 41 data
// pulses by their high width; the first pulse is discarded and the remaining
// 40 bits hold humidity, temperature and an 8-bit checksum. Any timeout or
// checksum mismatch sets read_error, and both values then read as zero.
// The block takes one transaction every cycle while its results are taken:
// the input register feeds a single pass of the phase machine whose result
// lands in the output register, where it is presented until the receiver
// takes it at an edge without out_stall. A stalled result holds the
// transaction behind it in the input register.
// Configuration registers are written through cfg_wr_en, cfg_index and
// cfg_wr_data and should only be changed while no reading is in progress.
module single_wire_sensor_frame_receiver_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [swsr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [swsr_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                req_type,
    input  logic                                line_level,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                drive_low,
    output logic                                busy_res,
    output logic                                done_res,
    output logic                                read_error,
    output logic [swsr_pkg::HUM_W-1:0]          humidity,
    output logic signed [swsr_pkg::TEMP_W-1:0]  temperature
);
    import swsr_pkg::*;

`include "single_wire_sensor_frame_receiver_unit_macros.svh"

    cfg_t    cfg;
    result_t core_result;

    // Input register: holds one accepted transaction until the phase
    // machine consumes it.
    logic    in_valid_reg, in_valid_next;
    logic    req_type_reg;
    logic    line_level_reg;

    // Output register: holds one result until the receiver takes it.
    logic    out_valid_reg, out_valid_next;
    result_t result_reg;

    logic    advance;
    logic    step;

    swsr_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    // The held transaction moves on whenever the output register is empty
    // or is being emptied in this cycle, so a full pipeline still flows at
    // one transaction per cycle.
    assign advance  = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    swsr_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .req_type   (req_type_reg),
        .line_level (line_level_reg),
        .cfg        (cfg),
        .result     (core_result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (!in_stall)
            in_valid_next = in_valid;

        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset; their valid flags guard them.
    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            req_type_reg   <= req_type;
            line_level_reg <= line_level;
        end
        if (step)
            result_reg <= core_result;
    end

    assign out_valid   = out_valid_reg;
    assign drive_low   = result_reg.drive_low;
    assign busy_res    = result_reg.busy;
    assign done_res    = result_reg.done;
    assign read_error  = result_reg.error;
    assign humidity    = result_reg.humidity;
    assign temperature = result_reg.temperature;

    // A completed reading always leaves the receiver idle.
    `SWSR_ASSERT_SAME(a_done_not_busy, out_valid_reg && result_reg.done, !result_reg.busy)
    // Driving the line low only happens while a reading is under way.
    `SWSR_ASSERT_SAME(a_drive_busy, out_valid_reg && result_reg.drive_low, result_reg.busy)
    // A failed reading reports zero for both values.
    `SWSR_ASSERT_SAME(a_error_zero,
        out_valid_reg && result_reg.done && result_reg.error,
        result_reg.humidity == '0 && result_reg.temperature == '0)
    // A consumed transaction always produces a result in the next cycle.
    `SWSR_ASSERT_NEXT(a_step_result, step, out_valid_reg)

endmodule
